FILE: src/assert_macros.svh
// Shared assertion forms, clocked on the rising edge and off while reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds on every edge.
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Consequent holds in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: src/crcc_pkg.sv
package crcc_pkg;

    localparam int REG_COUNT  = 4;
    localparam int ADDR_W     = 5;
    localparam int DATA_W     = 64;
    localparam int SETUP_W    = 42;
    localparam int SLOT_IDX_W = 3;
    localparam int MOD_STEPS  = 9;
    localparam int CNT_W      = 32;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_CLEAR,
        OP_RANGE,
        OP_CHECK
    } crcc_kind_t;

    typedef enum logic [1:0] {
        STATUS_OK,
        STATUS_SKIP,
        STATUS_MISMATCH,
        STATUS_RANGE
    } crcc_status_t;

    // Packing of one slot setup register.
    typedef struct packed {
        logic        enable;
        logic [7:0]  modulus;
        logic        upper;
        logic [2:0]  byte_idx;
        logic [28:0] id;
    } crcc_setup_t;

    // Classified frame handed from the front to the back.
    typedef struct packed {
        crcc_kind_t            kind;
        logic [SLOT_IDX_W-1:0] slot;
        logic [7:0]            counter;
        logic [7:0]            next;
    } crcc_op_t;

    // Slot state clear on a setup write.
    typedef struct packed {
        logic                  valid;
        logic [SLOT_IDX_W-1:0] slot;
    } crcc_clr_t;

    typedef struct packed {
        crcc_status_t     status;
        logic             monitored;
        logic [1:0]       slot_hit;
        logic [CNT_W-1:0] total_frames;
        logic [CNT_W-1:0] ok_frames;
        logic [CNT_W-1:0] mismatch_frames;
    } crcc_result_t;

endpackage

FILE: src/crcc_if.sv
interface crcc_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [28:0] frame_id;
    logic [3:0]  frame_length;
    logic [63:0] frame_payload;

    modport source (output valid, action, frame_id, frame_length, frame_payload,
                    input ready);
    modport sink (input valid, action, frame_id, frame_length, frame_payload,
                  output ready);
endinterface

interface crcc_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic        monitored;
    logic [1:0]  slot_hit;
    logic [31:0] total_frames;
    logic [31:0] ok_frames;
    logic [31:0] mismatch_frames;

    modport source (output valid, status, monitored, slot_hit, total_frames, ok_frames,
                    mismatch_frames, input ready);
    modport sink (input valid, status, monitored, slot_hit, total_frames, ok_frames,
                  mismatch_frames, output ready);
endinterface

FILE: src/crcc_cfg.sv
module crcc_cfg #(
    parameter int SLOTS = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [crcc_pkg::ADDR_W-1:0]   paddr,
    input  logic [crcc_pkg::DATA_W-1:0]   pwdata,
    output logic [crcc_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output crcc_pkg::crcc_setup_t         setup [SLOTS],
    output crcc_pkg::crcc_clr_t           clr
);
    import crcc_pkg::*;

    crcc_setup_t     setup_reg [SLOTS];
    logic [1:0]      reg_idx;
    logic            wr_en;

    assign reg_idx = paddr[ADDR_W-1:3];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < SLOTS; s++)
            begin
                setup_reg[s] <= '0;
            end
        end
        else if (wr_en)
        begin
            for (int s = 0; s < SLOTS; s++)
            begin
                if ((s < REG_COUNT) && (reg_idx == 2'(s)))
                begin
                    setup_reg[s] <= crcc_setup_t'(pwdata[SETUP_W-1:0]);
                end
            end
        end
    end

    always_comb
    begin
        prdata    = '0;
        clr.valid = 1'b0;
        clr.slot  = '0;
        for (int s = 0; s < SLOTS; s++)
        begin
            if ((s < REG_COUNT) && (reg_idx == 2'(s)))
            begin
                prdata    = {{(DATA_W-SETUP_W){1'b0}}, setup_reg[s]};
                clr.valid = wr_en;
                clr.slot  = SLOT_IDX_W'(s);
            end
        end
    end

    assign setup = setup_reg;

endmodule

FILE: src/crcc_front.sv
module crcc_front #(
    parameter int SLOTS = 4
) (
    input  logic                   clk,
    input  logic                   rst_n,
    crcc_in_if.sink                frame_in,
    input  crcc_pkg::crcc_setup_t  setup [SLOTS],
    output crcc_pkg::crcc_op_t     op,
    output logic                   op_valid,
    input  logic                   op_ready
);
    import crcc_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MOD,
        ST_PUSH
    } state_t;

    state_t                state_reg, state_next;
    crcc_op_t              op_reg, op_next;
    logic [8:0]            dvd_reg, dvd_next;
    logic [8:0]            dsr_reg, dsr_next;
    logic [8:0]            rem_reg, rem_next;
    logic [3:0]            cnt_reg, cnt_next;

    logic                  found;
    logic [SLOT_IDX_W-1:0] hit;
    crcc_setup_t           cfg;
    logic [7:0]            raw_byte;
    logic [7:0]            counter;
    crcc_kind_t            kind;
    logic [9:0]            rem_sh;

    // Lowest enabled slot with a matching id wins.
    always_comb
    begin
        found = 1'b0;
        hit   = '0;
        cfg   = '0;
        for (int s = SLOTS - 1; s >= 0; s--)
        begin
            if (setup[s].enable && (setup[s].id == frame_in.frame_id))
            begin
                found = 1'b1;
                hit   = SLOT_IDX_W'(s);
                cfg   = setup[s];
            end
        end
        raw_byte = frame_in.frame_payload[{cfg.byte_idx, 3'b000} +: 8];
        counter  = cfg.upper ? {4'h0, raw_byte[7:4] & 4'hF} : raw_byte;
        if (frame_in.action)
            kind = OP_CLEAR;
        else if (!found)
            kind = OP_NONE;
        else if ({1'b0, cfg.byte_idx} >= frame_in.frame_length)
            kind = OP_RANGE;
        else
            kind = OP_CHECK;
    end

    assign rem_sh = {rem_reg, dvd_reg[8]};

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        dvd_next   = dvd_reg;
        dsr_next   = dsr_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (frame_in.valid)
                begin
                    op_next.kind    = kind;
                    op_next.slot    = hit;
                    op_next.counter = counter;
                    op_next.next    = '0;
                    dvd_next        = {1'b0, counter} + 9'd1;
                    dsr_next        = (cfg.modulus == 8'd0) ? 9'd256 : {1'b0, cfg.modulus};
                    rem_next        = '0;
                    cnt_next        = 4'(MOD_STEPS - 1);
                    state_next      = (kind == OP_CHECK) ? ST_MOD : ST_PUSH;
                end
            end
            ST_MOD:
            begin
                // Restoring remainder, one dividend bit per cycle.
                dvd_next = dvd_reg << 1;
                if (rem_sh >= {1'b0, dsr_reg})
                    rem_next = 9'(rem_sh - {1'b0, dsr_reg});
                else
                    rem_next = rem_sh[8:0];
                cnt_next = cnt_reg - 4'd1;
                if (cnt_reg == 4'd0)
                begin
                    op_next.next = rem_next[7:0];
                    state_next   = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                if (op_ready)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            op_reg    <= '0;
            dvd_reg   <= '0;
            dsr_reg   <= '0;
            rem_reg   <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            dvd_reg   <= dvd_next;
            dsr_reg   <= dsr_next;
            rem_reg   <= rem_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign frame_in.ready = (state_reg == ST_IDLE);
    assign op_valid       = (state_reg == ST_PUSH);
    assign op             = op_reg;

endmodule

FILE: src/crcc_queue.sv
module crcc_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  crcc_pkg::crcc_op_t  push_op,
    input  logic                push_valid,
    output logic                push_ready,
    output crcc_pkg::crcc_op_t  pop_op,
    output logic                pop_valid,
    input  logic                pop_ready
);
    import crcc_pkg::*;

    crcc_op_t    mem_reg [2];
    logic        wptr_reg;
    logic        rptr_reg;
    logic [1:0]  count_reg;
    logic        do_push;
    logic        do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_op     = mem_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wptr_reg] <= push_op;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (do_push)
                wptr_reg <= ~wptr_reg;
            if (do_pop)
                rptr_reg <= ~rptr_reg;
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

FILE: src/crcc_back.sv
module crcc_back #(
    parameter int SLOTS = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  crcc_pkg::crcc_op_t  op,
    input  logic                op_valid,
    output logic                op_ready,
    input  crcc_pkg::crcc_clr_t clr,
    crcc_out_if.source          result_out
);
    import crcc_pkg::*;

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic             seen_reg [SLOTS];
    logic [7:0]       exp_reg  [SLOTS];
    logic [CNT_W-1:0] tot_reg  [SLOTS];
    logic [CNT_W-1:0] good_reg [SLOTS];
    logic [CNT_W-1:0] bad_reg  [SLOTS];

    logic             res_valid_reg;
    crcc_result_t     res_reg, res_next;

    logic [SW-1:0]    sidx;
    logic [SW-1:0]    cidx;
    logic             take;
    logic             slot_wr;
    logic             seen_new;
    logic [7:0]       exp_new;
    logic [CNT_W-1:0] tot_new;
    logic [CNT_W-1:0] good_new;
    logic [CNT_W-1:0] bad_new;

    assign sidx     = op.slot[SW-1:0];
    assign cidx     = clr.slot[SW-1:0];
    assign op_ready = !res_valid_reg || result_out.ready;
    assign take     = op_valid && op_ready;

    always_comb
    begin
        seen_new = seen_reg[sidx];
        exp_new  = exp_reg[sidx];
        tot_new  = tot_reg[sidx] + 32'd1;
        good_new = good_reg[sidx];
        bad_new  = bad_reg[sidx];
        slot_wr  = 1'b0;
        res_next = '0;
        case (op.kind)
            OP_RANGE:
            begin
                slot_wr          = 1'b1;
                res_next.status  = STATUS_RANGE;
            end
            OP_CHECK:
            begin
                slot_wr  = 1'b1;
                seen_new = 1'b1;
                exp_new  = op.next;
                if (!seen_reg[sidx])
                begin
                    good_new        = good_reg[sidx] + 32'd1;
                    res_next.status = STATUS_SKIP;
                end
                else if (op.counter != exp_reg[sidx])
                begin
                    bad_new         = bad_reg[sidx] + 32'd1;
                    res_next.status = STATUS_MISMATCH;
                end
                else
                begin
                    good_new        = good_reg[sidx] + 32'd1;
                    res_next.status = STATUS_OK;
                end
            end
            default:
            begin
                slot_wr = 1'b0;
            end
        endcase
        if (slot_wr)
        begin
            res_next.monitored       = 1'b1;
            res_next.slot_hit        = op.slot[1:0];
            res_next.total_frames    = tot_new;
            res_next.ok_frames       = good_new;
            res_next.mismatch_frames = bad_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
            for (int s = 0; s < SLOTS; s++)
            begin
                seen_reg[s] <= 1'b0;
                exp_reg[s]  <= '0;
                tot_reg[s]  <= '0;
                good_reg[s] <= '0;
                bad_reg[s]  <= '0;
            end
        end
        else
        begin
            if (take)
            begin
                res_valid_reg <= 1'b1;
                res_reg       <= res_next;
                if (op.kind == OP_CLEAR)
                begin
                    for (int s = 0; s < SLOTS; s++)
                    begin
                        seen_reg[s] <= 1'b0;
                        exp_reg[s]  <= '0;
                        tot_reg[s]  <= '0;
                        good_reg[s] <= '0;
                        bad_reg[s]  <= '0;
                    end
                end
                else if (slot_wr)
                begin
                    seen_reg[sidx] <= seen_new;
                    exp_reg[sidx]  <= exp_new;
                    tot_reg[sidx]  <= tot_new;
                    good_reg[sidx] <= good_new;
                    bad_reg[sidx]  <= bad_new;
                end
            end
            else if (result_out.ready)
            begin
                res_valid_reg <= 1'b0;
            end
            // Setup write drops the slot's history.
            if (clr.valid)
            begin
                seen_reg[cidx] <= 1'b0;
                exp_reg[cidx]  <= '0;
                tot_reg[cidx]  <= '0;
                good_reg[cidx] <= '0;
                bad_reg[cidx]  <= '0;
            end
        end
    end

    assign result_out.valid           = res_valid_reg;
    assign result_out.status          = res_reg.status;
    assign result_out.monitored       = res_reg.monitored;
    assign result_out.slot_hit        = res_reg.slot_hit;
    assign result_out.total_frames    = res_reg.total_frames;
    assign result_out.ok_frames       = res_reg.ok_frames;
    assign result_out.mismatch_frames = res_reg.mismatch_frames;

endmodule

FILE: src/can_rolling_counter_checker.sv
// CAN alive-counter checker. Each received frame beat on frame_in yields exactly one
// result beat on result_out. Up to four setup registers (APB, 64-bit data, register i
// at byte address 8*i) pick an id, the counter byte, full byte or upper nibble, a
// modulus (0 means 256) and an enable; writing one clears that slot's history. A
// frame whose counter is checked passes through the 9-step remainder unit that
// computes the next expected counter before the front hands it on; clear,
// unmatched and out-of-range frames go straight to the hand-off. The front takes
// no new frame until it has handed the last one on. A two-entry queue and the
// output register let the front take new frames while results wait downstream.
module can_rolling_counter_checker #(
    parameter int SLOTS = 4
) (
    input  logic                        clk,
    input  logic                        rst_n,
    crcc_in_if.sink                     frame_in,
    crcc_out_if.source                  result_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [crcc_pkg::ADDR_W-1:0] paddr,
    input  logic [crcc_pkg::DATA_W-1:0] pwdata,
    output logic [crcc_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);
    import crcc_pkg::*;

    crcc_setup_t setup [SLOTS];
    crcc_clr_t   clr;
    crcc_op_t    f_op;
    crcc_op_t    q_op;
    logic        f_valid;
    logic        f_ready;
    logic        q_valid;
    logic        q_ready;

    crcc_cfg #(.SLOTS(SLOTS)) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .setup   (setup),
        .clr     (clr)
    );

    crcc_front #(.SLOTS(SLOTS)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .frame_in (frame_in),
        .setup    (setup),
        .op       (f_op),
        .op_valid (f_valid),
        .op_ready (f_ready)
    );

    crcc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_op    (f_op),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .pop_op     (q_op),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready)
    );

    crcc_back #(.SLOTS(SLOTS)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .op         (q_op),
        .op_valid   (q_valid),
        .op_ready   (q_ready),
        .clr        (clr),
        .result_out (result_out)
    );

endmodule

FILE: src/crcc_checker.sv
`include "assert_macros.svh"

module crcc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  status,
    input logic        monitored,
    input logic [1:0]  slot_hit,
    input logic [31:0] total_frames,
    input logic [31:0] ok_frames,
    input logic [31:0] mismatch_frames
);

    logic [100:0] out_data;
    logic         out_rest_zero;

    assign out_data      = {status, monitored, slot_hit, total_frames, ok_frames,
                            mismatch_frames};
    assign out_rest_zero = ({status, slot_hit, total_frames, ok_frames,
                             mismatch_frames} == 100'd0);

    // Hold a stalled result beat.
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    `ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_data))

    // Unmonitored or cleared frames report all zero.
    `ASSERT_SAME(a_unmon_zero, clk, rst_n, out_valid && !monitored, out_rest_zero)

    // Front works on one frame at a time.
    `ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_valid && in_ready, !in_ready)

endmodule

bind can_rolling_counter_checker crcc_checker u_crcc_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (frame_in.valid),
    .in_ready        (frame_in.ready),
    .out_valid       (result_out.valid),
    .out_ready       (result_out.ready),
    .status          (result_out.status),
    .monitored       (result_out.monitored),
    .slot_hit        (result_out.slot_hit),
    .total_frames    (result_out.total_frames),
    .ok_frames       (result_out.ok_frames),
    .mismatch_frames (result_out.mismatch_frames)
);
